// ----- design/scrbs_pkg.sv -----
// Package for the sparse column row band splitter.
// Holds the field widths and configuration register indexes.
// It depends on nothing; sparse_column_row_band_splitter_unit imports it.
`default_nettype none

package scrbs_pkg;

  // Field widths
  localparam int unsigned ROW_W      = 31;
  localparam int unsigned BANDS_W    = 3;
  localparam int unsigned BAND_NUM_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;

  // Number of band limit registers
  localparam int unsigned LIMIT_REGS = 4;

  typedef logic [ROW_W-1:0]      word_t;
  typedef logic [BANDS_W-1:0]    nbands_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [BAND_NUM_W-1:0] band_num_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_BAND_LIMIT_0 = 3'd0;
  localparam cfg_idx_t CFG_BAND_LIMIT_1 = 3'd1;
  localparam cfg_idx_t CFG_BAND_LIMIT_2 = 3'd2;
  localparam cfg_idx_t CFG_BAND_LIMIT_3 = 3'd3;
  localparam cfg_idx_t CFG_BANDS_IN_USE = 3'd4;

endpackage : scrbs_pkg

`default_nettype wire

// ----- design/sparse_column_row_band_splitter_unit.sv -----
// Top level of the sparse column row band splitter: band placement, column
// snapshot and the band-by-band result sequencer.
// Depends on scrbs_pkg.
//
//   Port group | Dir | Handshake          | Carries
//   in_*       | in  | in_valid/in_stall  | row_index, has_entry, column_done
//   out_*      | out | out_valid/out_stall| column, band, start, pointer, flags
//   cfg_*      | in  | cfg_valid/cfg_ready| register index, write data
//
// One input request is taken per cycle unless stalled; band compares and
// counter updates happen in the accepting cycle. A column end copies the
// counts into a snapshot, sent one band per cycle while out_stall is low
// through the output register; a column gives n results. Only a further
// column end stalls while a snapshot is being sent. Reset is synchronous,
// active low and clears all counters; the configuration port is always ready.
`default_nettype none

module sparse_column_row_band_splitter_unit #(
  parameter int unsigned MAX_BANDS = 4
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // input requests
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire scrbs_pkg::word_t   in_row_index,
  input  wire                     in_has_entry,
  input  wire                     in_column_done,
  // result requests
  output logic                    out_valid,
  input  wire                     out_stall,
  output scrbs_pkg::word_t        out_column_number,
  output scrbs_pkg::band_num_t    out_band_number,
  output scrbs_pkg::word_t        out_band_start,
  output scrbs_pkg::word_t        out_band_pointer,
  output logic                    out_overflow_seen,
  output logic                    out_last_band,
  // configuration writes
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire scrbs_pkg::cfg_idx_t cfg_index,
  input  wire scrbs_pkg::word_t   cfg_data
);

  import scrbs_pkg::*;

  // Bands that can ever be used, and the width of a band index
  localparam int unsigned NB = (MAX_BANDS < LIMIT_REGS) ? MAX_BANDS : LIMIT_REGS;
  localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;

  typedef logic [BW-1:0] bidx_t;

  // Configuration registers
  word_t   band_limit_r [LIMIT_REGS];
  nbands_t bands_in_use_r;

  // Running state
  word_t   entry_offset_r;
  word_t   column_base_r;
  word_t   column_counter_r;
  logic    overflow_flag_r;
  word_t   band_count_r [NB];
  word_t   band_total_r [NB];

  // Column snapshot under emission
  logic    snap_valid_r;
  word_t   snap_col_r;
  logic    snap_ovf_r;
  nbands_t snap_n_r;
  word_t   snap_cnt_r [NB];
  word_t   start_run_r;
  bidx_t   k_r;

  // Output register
  logic      out_valid_r;
  word_t     out_column_number_r;
  band_num_t out_band_number_r;
  word_t     out_band_start_r;
  word_t     out_band_pointer_r;
  logic      out_overflow_seen_r;
  logic      out_last_band_r;

  // Effective band count: zero acts as one, saturate at NB
  nbands_t n_eff;
  always_comb begin
    n_eff = bands_in_use_r;
    if (n_eff == '0) n_eff = nbands_t'(1);
    if (n_eff > nbands_t'(NB)) n_eff = nbands_t'(NB);
  end

  // Configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LIMIT_REGS; i++) band_limit_r[i] <= '0;
      bands_in_use_r <= nbands_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        CFG_BAND_LIMIT_0, CFG_BAND_LIMIT_1, CFG_BAND_LIMIT_2, CFG_BAND_LIMIT_3: begin
          band_limit_r[cfg_index[1:0]] <= cfg_data;
        end
        CFG_BANDS_IN_USE: begin
          bands_in_use_r <= cfg_data[BANDS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Emitter handshake: move one band into the output register
  logic emit_go;
  logic emit_last;
  assign emit_go   = snap_valid_r && (!out_valid_r || !out_stall);
  assign emit_last = (nbands_t'(k_r) == snap_n_r - nbands_t'(1));

  // A column end needs the snapshot free (or freed this cycle)
  assign in_stall = in_column_done && snap_valid_r && !(emit_go && emit_last);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // Band placement: first used band whose limit exceeds the row
  logic [NB-1:0] hit;
  logic          placed;
  always_comb begin
    hit    = '0;
    placed = 1'b0;
    for (int k = 0; k < NB; k++) begin
      if (!placed && in_has_entry && (nbands_t'(k) < n_eff) &&
          (in_row_index < band_limit_r[k])) begin
        hit[k] = 1'b1;
        placed = 1'b1;
      end
    end
  end

  word_t band_count_nxt [NB];
  word_t entry_offset_nxt;
  logic  overflow_nxt;
  always_comb begin
    for (int k = 0; k < NB; k++) band_count_nxt[k] = band_count_r[k] + word_t'(hit[k]);
    entry_offset_nxt = entry_offset_r + word_t'(in_has_entry);
    overflow_nxt     = overflow_flag_r || (in_has_entry && !placed);
  end

  // Counters and the column snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_offset_r   <= '0;
      column_base_r    <= '0;
      column_counter_r <= '0;
      overflow_flag_r  <= 1'b0;
      for (int k = 0; k < NB; k++) band_count_r[k] <= '0;
      snap_valid_r     <= 1'b0;
      k_r              <= '0;
    end else begin
      if (in_acc) begin
        entry_offset_r <= entry_offset_nxt;
        if (in_column_done) begin
          for (int k = 0; k < NB; k++) begin
            band_count_r[k] <= '0;
            snap_cnt_r[k]   <= band_count_nxt[k];
          end
          overflow_flag_r  <= 1'b0;
          column_base_r    <= entry_offset_nxt;
          column_counter_r <= column_counter_r + word_t'(1);
          snap_col_r       <= column_counter_r;
          snap_ovf_r       <= overflow_nxt;
          snap_n_r         <= n_eff;
          start_run_r      <= column_base_r;
        end else begin
          for (int k = 0; k < NB; k++) band_count_r[k] <= band_count_nxt[k];
          overflow_flag_r <= overflow_nxt;
        end
      end
      // Sequencer over bands; a new snapshot takes priority over the clear
      if (emit_go) begin
        if (emit_last) begin
          k_r <= '0;
        end else begin
          k_r         <= k_r + bidx_t'(1);
          start_run_r <= start_run_r + snap_cnt_r[k_r];
        end
      end
      if (in_acc && in_column_done) begin
        snap_valid_r <= 1'b1;
      end else if (emit_go && emit_last) begin
        snap_valid_r <= 1'b0;
      end
    end
  end

  // Running band totals, updated as each band goes out
  word_t total_sum;
  assign total_sum = band_total_r[k_r] + snap_cnt_r[k_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NB; k++) band_total_r[k] <= '0;
    end else if (emit_go) begin
      band_total_r[k_r] <= total_sum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_column_number_r <= snap_col_r;
      out_band_number_r   <= band_num_t'(k_r);
      out_band_start_r    <= start_run_r;
      out_band_pointer_r  <= total_sum;
      out_overflow_seen_r <= snap_ovf_r;
      out_last_band_r     <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column_number = out_column_number_r;
  assign out_band_number   = out_band_number_r;
  assign out_band_start    = out_band_start_r;
  assign out_band_pointer  = out_band_pointer_r;
  assign out_overflow_seen = out_overflow_seen_r;
  assign out_last_band     = out_last_band_r;

  // Checks
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> snap_valid_r)
    else $error("input stalled with no column snapshot pending");

  a_snapshot_released: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && emit_last && !(in_acc && in_column_done)) |=> !snap_valid_r)
    else $error("snapshot still pending after its last band");

  a_overflow_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_has_entry && !placed && !in_column_done) |=> overflow_flag_r)
    else $error("dropped row did not set the overflow flag");

endmodule : sparse_column_row_band_splitter_unit

`default_nettype wire
